/* rtl/gbp_pkg.sv */
`timescale 1ns / 1ps
package gbp_pkg;

    localparam int PC_W      = 32;
    localparam int CTR_W     = 2;
    localparam int CNT_W     = 32;
    localparam int WIN_W     = 16;
    localparam int IBITS_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd2;

    localparam logic [IBITS_W-1:0]   RST_INDEX_BITS  = 4'd12;
    localparam logic [CTR_W-1:0]     RST_INIT_CTR    = 2'd1;
    localparam logic [WIN_W-1:0]     RST_WINDOW_LEN  = 16'd1000;

    localparam logic [CTR_W-1:0]     CTR_MAX         = 2'd3;
    localparam logic [CTR_W-1:0]     CTR_MIN         = 2'd0;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } t_state;

    typedef struct packed {
        logic update;
        logic miss;
        logic restart;
    } t_stats_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] total_misses;
        logic [CNT_W-1:0] total_branches;
        logic [WIN_W-1:0] window_misses;
        logic             window_done;
    } t_stats;

endpackage

/* rtl/gbp_req_if.sv */
`timescale 1ns / 1ps
interface gbp_req_if;
    logic                      valid;
    logic                      ready;
    logic [gbp_pkg::PC_W-1:0]  branch_pc;
    logic                      branch_taken;

    modport source (output valid, output branch_pc, output branch_taken, input ready);
    modport sink   (input valid, input branch_pc, input branch_taken, output ready);
endinterface

/* rtl/gbp_rsp_if.sv */
`timescale 1ns / 1ps
interface gbp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       predicted_taken;
    logic                       mispredicted;
    logic [gbp_pkg::CNT_W-1:0]  total_misses;
    logic [gbp_pkg::CNT_W-1:0]  total_branches;
    logic [gbp_pkg::WIN_W-1:0]  window_misses;
    logic                       window_done;

    modport source (output valid, output predicted_taken, output mispredicted,
                    output total_misses, output total_branches,
                    output window_misses, output window_done, input ready);
    modport sink   (input valid, input predicted_taken, input mispredicted,
                    input total_misses, input total_branches,
                    input window_misses, input window_done, output ready);
endinterface

/* rtl/gbp_ram.sv */
`timescale 1ns / 1ps
module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gbp_stats.sv */
`timescale 1ns / 1ps
module gbp_stats (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gbp_pkg::t_stats_ctl          i_ctl,
    input  logic [gbp_pkg::WIN_W-1:0]    i_window_len,
    output gbp_pkg::t_stats              o_next
);

    logic [gbp_pkg::CNT_W-1:0] r_miss, n_miss;
    logic [gbp_pkg::CNT_W-1:0] r_branch, n_branch;
    logic [gbp_pkg::WIN_W-1:0] r_wmiss, n_wmiss;
    logic [gbp_pkg::WIN_W-1:0] r_pos, n_pos;
    logic [gbp_pkg::WIN_W-1:0] w_wlen;
    logic                      w_done;

    always_comb begin
        // zero window length behaves as one
        w_wlen   = (i_window_len == '0) ? gbp_pkg::WIN_W'(1) : i_window_len;
        n_branch = (r_branch == '1) ? r_branch : r_branch + 1'b1;
        n_miss   = (i_ctl.miss && r_miss != '1) ? r_miss + 1'b1 : r_miss;
        n_wmiss  = (i_ctl.miss && r_wmiss != '1) ? r_wmiss + 1'b1 : r_wmiss;
        n_pos    = (r_pos != '1) ? r_pos + 1'b1 : r_pos;
        w_done   = (n_pos >= w_wlen);

        o_next.total_misses   = n_miss;
        o_next.total_branches = n_branch;
        o_next.window_misses  = w_done ? n_wmiss : '0;
        o_next.window_done    = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss   <= '0;
            r_branch <= '0;
            r_wmiss  <= '0;
            r_pos    <= '0;
        end else if (i_ctl.restart) begin
            r_wmiss  <= '0;
            r_pos    <= '0;
        end else if (i_ctl.update) begin
            r_miss   <= n_miss;
            r_branch <= n_branch;
            r_wmiss  <= w_done ? '0 : n_wmiss;
            r_pos    <= w_done ? '0 : n_pos;
        end
    end

endmodule

/* rtl/gshare_branch_predictor.sv */
`timescale 1ns / 1ps
// channel  | dir | payload                                          | request
// ---------+-----+--------------------------------------------------+------------------------
// i_req    | in  | branch_pc[31:0], branch_taken                    | one resolved branch
// o_rsp    | out | predicted_taken, mispredicted, total_misses,     | one result per branch
//          |     | total_branches, window_misses, window_done       |
// cfg      | in  | i_cfg_we, i_cfg_index[1:0], i_cfg_data[15:0]     | register write
//
// each request is accepted in the idle state, which issues the pattern table read; the
// lookup state then writes back the counter and registers the result; one branch in flight
// a clear pass over all 2**MAX_INDEX_BITS entries runs after reset and after every write of
// index_bits or initial_counter; no request is accepted during it
// a result waits in the output register; the next request is accepted meanwhile, and
// its update holds in the lookup state until the output register frees up
module gshare_branch_predictor #(
    parameter int MAX_INDEX_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gbp_req_if.sink                         i_req,
    gbp_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbp_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int IDX_W  = MAX_INDEX_BITS;
    localparam int DEPTH  = 1 << MAX_INDEX_BITS;
    localparam int UB_W   = $clog2(MAX_INDEX_BITS + 1);
    localparam int CMP_W  = (UB_W > gbp_pkg::IBITS_W) ? UB_W : gbp_pkg::IBITS_W;

    // control state
    gbp_pkg::t_state                 r_state, n_state;
    logic [IDX_W-1:0]                r_clr_addr, n_clr_addr;
    logic [IDX_W-1:0]                r_hist, n_hist;
    logic [gbp_pkg::IBITS_W-1:0]     r_index_bits;
    logic [gbp_pkg::CTR_W-1:0]       r_init_ctr;
    logic [gbp_pkg::WIN_W-1:0]       r_window_len;
    logic                            r_out_valid, n_out_valid;

    // request held across the table read
    logic [IDX_W-1:0]                r_idx;
    logic                            r_taken;

    // result register
    logic                            r_pred;
    logic                            r_miss;
    gbp_pkg::t_stats                 r_stats;

    logic [CMP_W-1:0]                w_bits_ext;
    logic [CMP_W-1:0]                w_used;
    logic [IDX_W-1:0]                w_mask;
    logic [IDX_W-1:0]                w_ridx;
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_done_lookup;
    logic                            w_clear_cfg;

    logic [gbp_pkg::CTR_W-1:0]       w_rdata;
    logic [gbp_pkg::CTR_W-1:0]       w_ctr_new;
    logic                            w_pred;
    logic                            w_miss;

    logic                            w_we;
    logic [IDX_W-1:0]                w_waddr;
    logic [gbp_pkg::CTR_W-1:0]       w_wdata;

    gbp_pkg::t_stats_ctl             w_stats_ctl;
    gbp_pkg::t_stats                 w_stats_next;

    // effective index width: zero acts as one, above the maximum clamps
    always_comb begin
        w_bits_ext = CMP_W'(r_index_bits);
        if (w_bits_ext == '0) begin
            w_used = CMP_W'(1);
        end else if (w_bits_ext > CMP_W'(MAX_INDEX_BITS)) begin
            w_used = CMP_W'(MAX_INDEX_BITS);
        end else begin
            w_used = w_bits_ext;
        end
        for (int k = 0; k < IDX_W; k++) begin
            w_mask[k] = (CMP_W'(k) < w_used);
        end
    end

    assign w_ridx     = (i_req.branch_pc[IDX_W-1:0] ^ r_hist) & w_mask;
    assign i_req.ready = (r_state == gbp_pkg::S_IDLE);
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_done_lookup = (r_state == gbp_pkg::S_LOOKUP) && w_out_free;

    // prediction and saturating counter step
    always_comb begin
        w_pred = w_rdata[1];
        w_miss = (w_pred != r_taken);
        if (r_taken) begin
            w_ctr_new = (w_rdata == gbp_pkg::CTR_MAX) ? w_rdata : w_rdata + 1'b1;
        end else begin
            w_ctr_new = (w_rdata == gbp_pkg::CTR_MIN) ? w_rdata : w_rdata - 1'b1;
        end
    end

    // table write port: clear sweep or write-back of the updated counter
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = r_init_ctr;
        if (r_state == gbp_pkg::S_CLEAR) begin
            w_we = 1'b1;
        end else if (w_done_lookup) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = w_ctr_new;
        end
    end

    assign w_clear_cfg = i_cfg_we &&
                         (i_cfg_index == gbp_pkg::CFG_INDEX_BITS ||
                          i_cfg_index == gbp_pkg::CFG_INIT_CTR);

    always_comb begin
        w_stats_ctl.update  = w_done_lookup;
        w_stats_ctl.miss    = w_miss;
        w_stats_ctl.restart = i_cfg_we && (i_cfg_index == gbp_pkg::CFG_WINDOW_LEN);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_hist     = r_hist;
        unique case (r_state)
            gbp_pkg::S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = gbp_pkg::S_IDLE;
                end
            end
            gbp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = gbp_pkg::S_LOOKUP;
                end
            end
            gbp_pkg::S_LOOKUP: begin
                if (w_out_free) begin
                    n_hist  = {r_hist[IDX_W-2:0], r_taken};
                    n_state = gbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gbp_pkg::S_CLEAR;
            end
        endcase
        // table clear restarts the sweep and drops the history
        if (w_clear_cfg) begin
            n_state    = gbp_pkg::S_CLEAR;
            n_clr_addr = '0;
            n_hist     = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_done_lookup) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gbp_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_hist       <= '0;
            r_out_valid  <= 1'b0;
            r_index_bits <= gbp_pkg::RST_INDEX_BITS;
            r_init_ctr   <= gbp_pkg::RST_INIT_CTR;
            r_window_len <= gbp_pkg::RST_WINDOW_LEN;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gbp_pkg::CFG_INDEX_BITS: begin
                        r_index_bits <= i_cfg_data[gbp_pkg::IBITS_W-1:0];
                    end
                    gbp_pkg::CFG_INIT_CTR: begin
                        r_init_ctr <= i_cfg_data[gbp_pkg::CTR_W-1:0];
                    end
                    gbp_pkg::CFG_WINDOW_LEN: begin
                        r_window_len <= i_cfg_data[gbp_pkg::WIN_W-1:0];
                    end
                    default: begin
                        // writes beyond the register list are dropped
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx   <= w_ridx;
            r_taken <= i_req.branch_taken;
        end
        if (w_done_lookup) begin
            r_pred  <= w_pred;
            r_miss  <= w_miss;
            r_stats <= w_stats_next;
        end
    end

    gbp_ram #(
        .WIDTH (gbp_pkg::CTR_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_ridx),
        .o_rdata (w_rdata)
    );

    gbp_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_stats_ctl),
        .i_window_len (r_window_len),
        .o_next       (w_stats_next)
    );

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.predicted_taken = r_pred;
    assign o_rsp.mispredicted    = r_miss;
    assign o_rsp.total_misses    = r_stats.total_misses;
    assign o_rsp.total_branches  = r_stats.total_branches;
    assign o_rsp.window_misses   = r_stats.window_misses;
    assign o_rsp.window_done     = r_stats.window_done;

endmodule

/* rtl/gbp_checker.sv */
`timescale 1ns / 1ps
module gbp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_mispredicted,
    input  logic [gbp_pkg::CNT_W-1:0]   i_total_misses,
    input  logic [gbp_pkg::CNT_W-1:0]   i_total_branches,
    input  logic [gbp_pkg::WIN_W-1:0]   i_window_misses,
    input  logic                        i_window_done
);

    // a stalled result stays valid and keeps its branch count
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_total_branches))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // window count only reported when a window closes
    a_win_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_window_done |-> i_window_misses == '0)
        else $error("window misses without window close");

    // misses never exceed branches, and a miss is counted
    a_miss_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_total_misses <= i_total_branches &&
                        (!i_mispredicted || i_total_misses != '0))
        else $error("miss count inconsistent");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_mispredicted   (o_rsp.mispredicted),
    .i_total_misses   (o_rsp.total_misses),
    .i_total_branches (o_rsp.total_branches),
    .i_window_misses  (o_rsp.window_misses),
    .i_window_done    (o_rsp.window_done)
);

/* sim/gshare_outcome_checker.sv */
`timescale 1ns / 1ps
module gshare_outcome_checker #(
    parameter int MAX_INDEX_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gbp_req_if                              req,
    gbp_rsp_if                              rsp,
    input  logic                            i_cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbp_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);

    localparam int TABLE_DEPTH = 1 << MAX_INDEX_BITS;

    typedef struct packed {
        logic                         pred;
        logic                         miss;
        logic [gbp_pkg::CNT_W-1:0]    misses;
        logic [gbp_pkg::CNT_W-1:0]    branches;
        logic [gbp_pkg::WIN_W-1:0]    win_misses;
        logic                         win_done;
    } t_branch_outcome;

    t_branch_outcome expected_outcomes[$];

    // mirror of the block state
    logic [gbp_pkg::CTR_W-1:0]     pht [0:TABLE_DEPTH-1];
    logic [MAX_INDEX_BITS-1:0]     ghist;
    logic [gbp_pkg::CNT_W-1:0]     miss_total;
    logic [gbp_pkg::CNT_W-1:0]     branch_total;
    logic [gbp_pkg::WIN_W-1:0]     win_miss;
    logic [gbp_pkg::WIN_W-1:0]     win_pos;
    logic [gbp_pkg::IBITS_W-1:0]   idx_bits;
    logic [gbp_pkg::CTR_W-1:0]     init_ctr;
    logic [gbp_pkg::WIN_W-1:0]     win_len;

    int mismatches = 0;

    task automatic clear_history();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            pht[i] = init_ctr;
        end
        ghist = '0;
    endtask

    function automatic t_branch_outcome predict_branch(input logic [gbp_pkg::PC_W-1:0] pc,
                                                       input logic taken);
        int unsigned                used;
        logic [31:0]                slot;
        logic [gbp_pkg::CTR_W-1:0]  ctr;
        logic [gbp_pkg::WIN_W-1:0]  span;
        t_branch_outcome            r;
        // out-of-range index widths are clamped
        used = (idx_bits == 0) ? 1 : (idx_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : idx_bits;
        slot = (pc ^ 32'(ghist)) & ((32'd1 << used) - 32'd1);
        ctr  = pht[slot[MAX_INDEX_BITS-1:0]];
        r      = '0;
        r.pred = (ctr >= 2'd2);
        r.miss = (r.pred != taken);
        span   = (win_len == '0) ? 16'd1 : win_len;
        if (taken && ctr != gbp_pkg::CTR_MAX) begin
            ctr = ctr + 2'd1;
        end else if (!taken && ctr != gbp_pkg::CTR_MIN) begin
            ctr = ctr - 2'd1;
        end
        pht[slot[MAX_INDEX_BITS-1:0]] = ctr;
        ghist = {ghist[MAX_INDEX_BITS-2:0], taken};
        if (branch_total != '1) branch_total = branch_total + 1'b1;
        if (r.miss) begin
            if (miss_total != '1) miss_total = miss_total + 1'b1;
            if (win_miss != '1) win_miss = win_miss + 1'b1;
        end
        if (win_pos != '1) win_pos = win_pos + 1'b1;
        if (win_pos >= span) begin
            r.win_done   = 1'b1;
            r.win_misses = win_miss;
            win_pos      = '0;
            win_miss     = '0;
        end
        r.misses   = miss_total;
        r.branches = branch_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_branch_outcome want;
        if (!i_rst_n) begin
            idx_bits     = gbp_pkg::RST_INDEX_BITS;
            init_ctr     = gbp_pkg::RST_INIT_CTR;
            win_len      = gbp_pkg::RST_WINDOW_LEN;
            miss_total   = '0;
            branch_total = '0;
            win_miss     = '0;
            win_pos      = '0;
            clear_history();
            expected_outcomes.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, %s %0h/%0h",
                             $time, "expected none, actual",
                             rsp.total_branches, rsp.total_misses);
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("predicted_taken", 32'(want.pred), 32'(rsp.predicted_taken));
                    check_field("mispredicted", 32'(want.miss), 32'(rsp.mispredicted));
                    check_field("total_misses", want.misses, rsp.total_misses);
                    check_field("total_branches", want.branches, rsp.total_branches);
                    check_field("window_misses", 32'(want.win_misses), 32'(rsp.window_misses));
                    check_field("window_done", 32'(want.win_done), 32'(rsp.window_done));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gbp_pkg::CFG_INDEX_BITS: begin
                        idx_bits = i_cfg_data[gbp_pkg::IBITS_W-1:0];
                        clear_history();
                    end
                    gbp_pkg::CFG_INIT_CTR: begin
                        init_ctr = i_cfg_data[gbp_pkg::CTR_W-1:0];
                        clear_history();
                    end
                    gbp_pkg::CFG_WINDOW_LEN: begin
                        win_len  = i_cfg_data[gbp_pkg::WIN_W-1:0];
                        win_pos  = '0;
                        win_miss = '0;
                    end
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                expected_outcomes.push_back(predict_branch(req.branch_pc, req.branch_taken));
        end
        o_pending = expected_outcomes.size();
        o_errors  = mismatches;
    end

endmodule

/* sim/gshare_branch_predictor_tb.sv */
`timescale 1ns / 1ps
module gshare_branch_predictor_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LOOP_SLOTS  = 8;

    logic clk;
    logic rst_n;
    logic                            cfg_we;
    logic [gbp_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [gbp_pkg::CFG_DAT_W-1:0]   cfg_data;
    int                              errors;
    int                              pending;
    int                              cycle_count = 0;

    // branch loops with a fixed trip count, revisited to train the counters
    logic [gbp_pkg::PC_W-1:0] loop_pc   [LOOP_SLOTS];
    int                       loop_trip [LOOP_SLOTS];
    int                       loop_iter [LOOP_SLOTS];
    int                       burst_left = 0;

    // response-side stall pattern
    int ready_mode = 0;
    int ready_left = 0;

    gbp_req_if req_ch ();
    gbp_rsp_if rsp_ch ();

    gshare_branch_predictor #(
        .MAX_INDEX_BITS(12)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gshare_outcome_checker #(
        .MAX_INDEX_BITS(12)
    ) u_outcome_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gshare_branch_predictor_tb: FAIL");
            $finish;
        end
    end

    // receiver: stretches of always-ready, coin-flip ready, and mostly stalled
    always @(negedge clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(8, 40);
        end
        ready_left--;
        case (ready_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= (ready_left % 4 == 0);
        endcase
    end

    // one request, held until the block takes it
    task automatic send_branch(input logic [gbp_pkg::PC_W-1:0] pc, input logic taken);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.branch_pc    <= pc;
        req_ch.branch_taken <= taken;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // stop sending until every outstanding result has come back
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // also waits out a table clear pass
    task automatic wait_idle();
        drain();
        while (!req_ch.ready) @(negedge clk);
    endtask

    task automatic write_reg(input logic [gbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gbp_pkg::CFG_DAT_W-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input logic [gbp_pkg::IBITS_W-1:0] ib,
                                  input logic [gbp_pkg::CTR_W-1:0] init,
                                  input logic [gbp_pkg::WIN_W-1:0] wlen);
        write_reg(gbp_pkg::CFG_WINDOW_LEN, wlen);
        write_reg(gbp_pkg::CFG_INDEX_BITS, 16'(ib));
        write_reg(gbp_pkg::CFG_INIT_CTR, 16'(init));
        wait_idle();
    endtask

    task automatic reseed_loops();
        for (int j = 0; j < LOOP_SLOTS; j++) begin
            loop_pc[j]   = $urandom;
            loop_trip[j] = $urandom_range(1, 8);
            loop_iter[j] = 0;
        end
    endtask

    // mostly loop-shaped branch streams, some random outcomes, some noise
    task automatic branch_stream(input int n);
        int                       pick;
        int                       j;
        logic [gbp_pkg::PC_W-1:0] pc;
        logic                     taken;
        reseed_loops();
        for (int k = 0; k < n; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
            end
            burst_left--;
            if (k == n / 2) drain();
            pick = $urandom_range(0, 99);
            j    = $urandom_range(0, LOOP_SLOTS - 1);
            if (pick < 60) begin
                pc           = loop_pc[j];
                taken        = (loop_iter[j] != loop_trip[j] - 1);
                loop_iter[j] = (loop_iter[j] + 1) % loop_trip[j];
            end else if (pick < 85) begin
                pc    = loop_pc[j];
                taken = 1'($urandom_range(0, 1));
            end else begin
                pc    = $urandom;
                taken = 1'($urandom_range(0, 1));
            end
            send_branch(pc, taken);
        end
    endtask

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.branch_pc    = '0;
        req_ch.branch_taken = 1'b0;
        rsp_ch.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = gbp_pkg::CFG_INDEX_BITS;
        cfg_data            = '0;
        rst_n               = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: address extremes and a counter walk, at reset settings
        wait_idle();
        send_branch(32'h0000_0000, 1'b0);
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'hAAAA_AAAA, 1'b1);
        send_branch(32'h5555_5555, 1'b0);
        send_branch(32'h8000_0000, 1'b1);
        send_branch(32'h0000_0FFF, 1'b1);
        repeat (6) send_branch(32'h0000_0040, 1'b1);
        repeat (6) send_branch(32'h0000_0040, 1'b0);

        // narrowest index, zero initial counters, one-branch windows
        apply_settings(4'd1, 2'd0, 16'd1);
        branch_stream(110);
        // index width zero clamps up, zero window length acts as one
        apply_settings(4'd0, 2'd3, 16'd0);
        branch_stream(110);
        // index width above the table size clamps down
        apply_settings(4'd15, 2'd2, 16'd7);
        branch_stream(110);
        // full table, longest window
        apply_settings(4'd12, 2'd1, 16'hFFFF);
        branch_stream(110);
        apply_settings(4'($urandom_range(2, 11)), 2'($urandom_range(0, 3)),
                       16'($urandom_range(2, 40)));
        branch_stream(110);
        apply_settings(4'd4, 2'd3, 16'd3);
        branch_stream(55);
        // window restart in mid-window, table and history untouched
        write_reg(gbp_pkg::CFG_WINDOW_LEN, 16'd5);
        branch_stream(55);
        // table clear from the initial counter alone
        write_reg(gbp_pkg::CFG_INIT_CTR, 16'd0);
        branch_stream(55);

        drain();
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("gshare_branch_predictor_tb: PASS");
        end else begin
            $display("gshare_branch_predictor_tb: FAIL");
        end
        $finish;
    end

endmodule
